>>> rtl/u8cjk_pkg.sv
package u8cjk_pkg;

  // queue between decoder and flag collector
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned CpW = 21;

  // one decoded byte as seen by the back part
  typedef struct packed {
    logic cjk_hit;
    logic high_bit;
    logic last;
  } u8cjk_entry_t;

  // cjk codepoint ranges, inclusive
  localparam logic [CpW-1:0] R0Lo = 21'h02E80, R0Hi = 21'h02EFF;
  localparam logic [CpW-1:0] R1Lo = 21'h03000, R1Hi = 21'h0303F;
  localparam logic [CpW-1:0] R2Lo = 21'h03400, R2Hi = 21'h04DBF;
  localparam logic [CpW-1:0] R3Lo = 21'h04E00, R3Hi = 21'h09FFF;
  localparam logic [CpW-1:0] R4Lo = 21'h0F900, R4Hi = 21'h0FAFF;
  localparam logic [CpW-1:0] R5Lo = 21'h0FE10, R5Hi = 21'h0FE1F;
  localparam logic [CpW-1:0] R6Lo = 21'h0FE30, R6Hi = 21'h0FE4F;
  localparam logic [CpW-1:0] R7Lo = 21'h0FF00, R7Hi = 21'h0FFEF;
  localparam logic [CpW-1:0] R8Lo = 21'h20000, R8Hi = 21'h2FA1F;

  function automatic logic in_cjk(input logic [CpW-1:0] cp);
    in_cjk = (cp >= R0Lo && cp <= R0Hi) || (cp >= R1Lo && cp <= R1Hi) ||
             (cp >= R2Lo && cp <= R2Hi) || (cp >= R3Lo && cp <= R3Hi) ||
             (cp >= R4Lo && cp <= R4Hi) || (cp >= R5Lo && cp <= R5Hi) ||
             (cp >= R6Lo && cp <= R6Hi) || (cp >= R7Lo && cp <= R7Hi) ||
             (cp >= R8Lo && cp <= R8Hi);
  endfunction

endpackage

>>> rtl/u8cjk_front.sv
module u8cjk_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [7:0]              byte_i,
  input  logic                    last_i,
  output u8cjk_pkg::u8cjk_entry_t entry_o
);
  import u8cjk_pkg::*;

  logic [7:0]  lead_q, lead_d;
  logic [17:0] payload_q, payload_d;
  logic [1:0]  seen_q, seen_d;
  logic [1:0]  expect_q, expect_d;

  logic           is_cont;
  logic           taken;
  logic           do_close;
  logic [1:0]     seen_inc;
  logic [17:0]    payload_inc;
  logic [1:0]     need;
  logic [CpW-1:0] cp;

  // lead class of the incoming byte
  always_comb begin
    if (byte_i[7:5] == 3'b110) begin
      need = 2'd1;
    end else if (byte_i[7:4] == 4'b1110) begin
      need = 2'd2;
    end else if (byte_i[7:3] == 5'b11110) begin
      need = 2'd3;
    end else begin
      need = 2'd0;
    end
  end

  assign is_cont     = (byte_i[7:6] == 2'b10);
  assign taken       = (expect_q != 2'd0) && is_cont;
  assign seen_inc    = seen_q + 2'd1;
  assign payload_inc = {payload_q[11:0], byte_i[5:0]};
  assign do_close    = taken && ((seen_inc == expect_q) || last_i);

  // codepoint of a sequence that closes on this byte
  always_comb begin
    case (seen_inc)
      2'd1:    cp = {10'd0, lead_q[4:0], payload_inc[5:0]};
      2'd2:    cp = {5'd0, lead_q[3:0], payload_inc[11:0]};
      2'd3:    cp = {lead_q[2:0], payload_inc};
      default: cp = '0;
    endcase
  end

  assign entry_o.cjk_hit  = do_close && in_cjk(cp);
  assign entry_o.high_bit = byte_i[7];
  assign entry_o.last     = last_i;

  // next decode state
  always_comb begin
    lead_d    = lead_q;
    payload_d = payload_q;
    seen_d    = seen_q;
    expect_d  = expect_q;
    if (last_i || (taken && seen_inc == expect_q)) begin
      lead_d    = '0;
      payload_d = '0;
      seen_d    = '0;
      expect_d  = '0;
    end else if (taken) begin
      payload_d = payload_inc;
      seen_d    = seen_inc;
    end else if (need != 2'd0) begin
      lead_d    = byte_i;
      payload_d = '0;
      seen_d    = '0;
      expect_d  = need;
    end else begin
      lead_d    = '0;
      payload_d = '0;
      seen_d    = '0;
      expect_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q    <= '0;
      payload_q <= '0;
      seen_q    <= '0;
      expect_q  <= '0;
    end else if (push_i) begin
      lead_q    <= lead_d;
      payload_q <= payload_d;
      seen_q    <= seen_d;
      expect_q  <= expect_d;
    end
  end

endmodule

>>> rtl/u8cjk_queue.sv
module u8cjk_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  u8cjk_pkg::u8cjk_entry_t entry_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output logic                    avail_o,
  output u8cjk_pkg::u8cjk_entry_t entry_o
);
  import u8cjk_pkg::*;

  u8cjk_entry_t     slot_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign avail_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/u8cjk_back.sv
module u8cjk_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    avail_i,
  input  u8cjk_pkg::u8cjk_entry_t entry_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    has_cjk_o,
  output logic                    needs_unicode_o
);
  import u8cjk_pkg::*;

  logic cjk_q, cjk_d;
  logic hi_q, hi_d;
  logic valid_q, valid_d;
  logic res_cjk_q, res_hi_q;
  logic slot_free;

  // a last item needs the result register free
  assign slot_free = !valid_q || out_ready_i;
  assign pop_o     = avail_i && (!entry_i.last || slot_free);

  assign cjk_d = cjk_q | entry_i.cjk_hit;
  assign hi_d  = hi_q | entry_i.high_bit;

  always_comb begin
    valid_d = valid_q && !out_ready_i;
    if (pop_o && entry_i.last) begin
      valid_d = 1'b1;
    end
  end

  // sticky flags and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cjk_q   <= 1'b0;
      hi_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (pop_o) begin
        cjk_q <= entry_i.last ? 1'b0 : cjk_d;
        hi_q  <= entry_i.last ? 1'b0 : hi_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.last) begin
      res_cjk_q <= cjk_d;
      res_hi_q  <= hi_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign has_cjk_o       = res_cjk_q;
  assign needs_unicode_o = res_hi_q;

endmodule

>>> rtl/utf8_cjk_text_classifier_unit.sv
// utf-8 text classifier: one byte per cycle while its four-item queue is not full
// result path: the last byte's entry goes into the queue, then into the result register once it is free
// throughput: one byte per cycle; the queue stalls input only when the result
// register is held by the consumer and four bytes are waiting
// reset: asynchronous active low; clears decode state, flags, queue and result valid
module utf8_cjk_text_classifier_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] text_byte
  input  logic       s_axis_tlast_i,  // end_of_text
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o   // [0] has_cjk, [1] needs_unicode, [7:2] zero
);
  import u8cjk_pkg::*;

  u8cjk_entry_t front_entry;
  u8cjk_entry_t back_entry;
  logic         push;
  logic         full;
  logic         pop;
  logic         avail;
  logic         has_cjk;
  logic         needs_unicode;

  assign s_axis_tready_o = !full;
  assign push            = s_axis_tvalid_i && !full;

  // byte decoder
  u8cjk_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .byte_i  (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .entry_o (front_entry)
  );

  // decoupling queue
  u8cjk_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .entry_o (back_entry)
  );

  // flag collector and result register
  u8cjk_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .avail_i         (avail),
    .entry_i         (back_entry),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .has_cjk_o       (has_cjk),
    .needs_unicode_o (needs_unicode)
  );

  assign m_axis_tdata_o = {6'd0, needs_unicode, has_cjk};

endmodule

>>> tb/u8cjk_flag_checker.sv
// watches both streams, decodes the text bytes on its own and checks the flags
module u8cjk_flag_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,   // [7:0] text_byte
  input  logic        in_last_i,   // end_of_text
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_data_i,  // [0] has_cjk, [1] needs_unicode, [7:2] zero
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);

  typedef struct packed {
    logic has_cjk;
    logic needs_unicode;
  } text_flags_t;

  // flags of finished texts, oldest first
  text_flags_t flags_due[$];

  // decode state of the text in flight
  logic [7:0]  lead_byte;
  logic [17:0] payload;
  logic [1:0]  cont_got;
  logic [1:0]  cont_want;
  logic        cjk_seen;
  logic        hi_seen;
  int unsigned texts_done;

  function automatic logic cjk_codepoint(input logic [20:0] cp);
    return (cp >= 21'h02E80 && cp <= 21'h02EFF) || (cp >= 21'h03000 && cp <= 21'h0303F) ||
           (cp >= 21'h03400 && cp <= 21'h04DBF) || (cp >= 21'h04E00 && cp <= 21'h09FFF) ||
           (cp >= 21'h0F900 && cp <= 21'h0FAFF) || (cp >= 21'h0FE10 && cp <= 21'h0FE1F) ||
           (cp >= 21'h0FE30 && cp <= 21'h0FE4F) || (cp >= 21'h0FF00 && cp <= 21'h0FFEF) ||
           (cp >= 21'h20000 && cp <= 21'h2FA1F);
  endfunction

  task automatic report(input string what);
    fail_count_o++;
    $display("[%0t] text %0d: %s", $realtime, texts_done, what);
  endtask

  // lead mask depends on how many continuation bytes are present
  task automatic decode_open(input logic [1:0] k);
    logic [20:0] head;
    logic [20:0] cp;
    case (k)
      2'd1:    head = {13'd0, lead_byte & 8'h1F};
      2'd2:    head = {13'd0, lead_byte & 8'h0F};
      default: head = {13'd0, lead_byte & 8'h07};
    endcase
    cp = (head << (6 * k)) | {3'd0, payload};
    if (cjk_codepoint(cp)) cjk_seen = 1'b1;
  endtask

  task automatic drop_open();
    lead_byte = 8'd0;
    payload   = 18'd0;
    cont_got  = 2'd0;
    cont_want = 2'd0;
  endtask

  // one accepted text byte
  task automatic absorb_byte(input logic [7:0] b, input logic eot);
    logic       took;
    logic [1:0] need;
    text_flags_t done;
    took = 1'b0;
    need = 2'd0;
    if (b[7]) hi_seen = 1'b1;
    // open sequence: continuation extends it, anything else breaks it
    if (cont_want != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        payload  = {payload[11:0], b[5:0]};
        cont_got = cont_got + 2'd1;
        took     = 1'b1;
        if (cont_got == cont_want) begin
          decode_open(cont_got);
          drop_open();
        end
      end else begin
        drop_open();
      end
    end
    // lead classification
    if (!took) begin
      casez (b)
        8'b110?????: need = 2'd1;
        8'b1110????: need = 2'd2;
        8'b11110???: need = 2'd3;
        default:     need = 2'd0;
      endcase
      if (need != 2'd0) begin
        lead_byte = b;
        payload   = 18'd0;
        cont_got  = 2'd0;
        cont_want = need;
      end
    end
    // end of text: decode a cut-short sequence, emit, start fresh
    if (eot) begin
      if (cont_want != 2'd0 && cont_got != 2'd0) decode_open(cont_got);
      done.has_cjk       = cjk_seen;
      done.needs_unicode = hi_seen;
      flags_due = {flags_due, done};
      drop_open();
      cjk_seen = 1'b0;
      hi_seen  = 1'b0;
    end
  endtask

  // compare results first; a result never belongs to a byte of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    text_flags_t want;
    if (!rst_ni) begin
      drop_open();
      cjk_seen = 1'b0;
      hi_seen  = 1'b0;
      flags_due.delete();
      outstanding_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (flags_due.size() == 0) begin
          report($sformatf("unexpected result %02h", out_data_i));
        end else begin
          want = flags_due.pop_front();
          if (out_data_i[0] !== want.has_cjk)
            report($sformatf("has_cjk %b, want %b", out_data_i[0], want.has_cjk));
          if (out_data_i[1] !== want.needs_unicode)
            report($sformatf("needs_unicode %b, want %b", out_data_i[1], want.needs_unicode));
          if (out_data_i[7:2] !== 6'd0)
            report($sformatf("pad bits %b, want zero", out_data_i[7:2]));
          texts_done++;
        end
      end
      if (in_valid_i && in_ready_i) absorb_byte(in_data_i, in_last_i);
      outstanding_o = flags_due.size();
    end
  end

endmodule

>>> tb/utf8_cjk_text_classifier_unit_tb.sv
// byte stream source, result sink and verdict for the utf-8 cjk classifier
module utf8_cjk_text_classifier_unit_tb;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned ByteTarget = 1600;

  logic       clk;
  logic       rst_n;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;
  logic        calm;

  // bytes of the text being built, plus the directed texts (bit 8 = last)
  logic [7:0] text_bytes[$];
  logic [8:0] directed_items[23];

  utf8_cjk_text_classifier_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  u8cjk_flag_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (s_tvalid),
    .in_ready_i    (s_tready),
    .in_data_i     (s_tdata),
    .in_last_i     (s_tlast),
    .out_valid_i   (m_tvalid),
    .out_ready_i   (m_tready),
    .out_data_i    (m_tdata),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result sink with random stalls, none during the calm stretch
  initial m_tready = 1'b0;
  always @(negedge clk) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("utf8_cjk_text_classifier_unit_tb: errors");
        $finish;
      end
    end
  end

  function automatic logic [20:0] range_edge(input int idx, input logic upper);
    logic [20:0] lo, hi;
    case (idx)
      0:       begin lo = 21'h02E80; hi = 21'h02EFF; end
      1:       begin lo = 21'h03000; hi = 21'h0303F; end
      2:       begin lo = 21'h03400; hi = 21'h04DBF; end
      3:       begin lo = 21'h04E00; hi = 21'h09FFF; end
      4:       begin lo = 21'h0F900; hi = 21'h0FAFF; end
      5:       begin lo = 21'h0FE10; hi = 21'h0FE1F; end
      6:       begin lo = 21'h0FE30; hi = 21'h0FE4F; end
      7:       begin lo = 21'h0FF00; hi = 21'h0FFEF; end
      default: begin lo = 21'h20000; hi = 21'h2FA1F; end
    endcase
    return upper ? hi : lo;
  endfunction

  // codepoints biased to the cjk range edges
  function automatic logic [20:0] pick_codepoint();
    int          r;
    int          idx;
    logic [20:0] lo, hi;
    r = $urandom_range(99);
    if (r < 15) return 21'($urandom_range(21'h1FFFFF));
    if (r < 30) return 21'($urandom_range(16'hFFFF));
    idx = $urandom_range(8);
    lo  = range_edge(idx, 1'b0);
    hi  = range_edge(idx, 1'b1);
    case ($urandom_range(4))
      0:       return lo - 21'd1;
      1:       return lo;
      2:       return hi;
      3:       return hi + 21'd1;
      default: return 21'($urandom_range(hi, lo));
    endcase
  endfunction

  // one more byte at the tail of the text being built
  task automatic append_byte(input logic [7:0] b);
    text_bytes = {text_bytes, b};
  endtask

  // utf-8 encoding, sometimes one byte longer than needed
  task automatic add_char(input logic [20:0] cp);
    int len;
    if (cp < 21'h80) len = 1;
    else if (cp < 21'h800) len = 2;
    else if (cp < 21'h10000) len = 3;
    else len = 4;
    if (len < 4 && $urandom_range(9) == 0) len++;
    case (len)
      1: append_byte({1'b0, cp[6:0]});
      2: begin
        append_byte({3'b110, cp[10:6]});
        append_byte({2'b10, cp[5:0]});
      end
      3: begin
        append_byte({4'b1110, cp[15:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
      default: begin
        append_byte({5'b11110, cp[20:18]});
        append_byte({2'b10, cp[17:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // lead with too few continuations; at the end of a text it is cut short
  task automatic add_broken();
    int len;
    int conts;
    len   = $urandom_range(4, 2);
    conts = $urandom_range(len - 2);
    case (len)
      2:       append_byte({3'b110, 5'($urandom)});
      3:       append_byte({4'b1110, 4'($urandom)});
      default: append_byte({5'b11110, 3'($urandom)});
    endcase
    repeat (conts) append_byte({2'b10, 6'($urandom)});
  endtask

  task automatic build_text();
    int parts;
    int r;
    text_bytes.delete();
    parts = ($urandom_range(19) == 0) ? $urandom_range(40, 20) : $urandom_range(6, 1);
    repeat (parts) begin
      r = $urandom_range(99);
      if (r < 70) add_char(pick_codepoint());
      else if (r < 85) append_byte(8'($urandom));
      else add_broken();
    end
  endtask

  // one item to the block; returns at the falling edge after acceptance
  task automatic push_byte(input logic [7:0] b, input logic eot);
    while (!calm && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    calm = (bytes_sent >= 500 && bytes_sent < 800);
    @(negedge clk);
  endtask

  // hold the source until every pending result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    s_tvalid     = 1'b0;
    s_tdata      = 8'd0;
    s_tlast      = 1'b0;
    rst_n        = 1'b0;
    calm         = 1'b0;
    bytes_sent   = 0;
    quiet_cycles = 0;
    // plain ascii, single ff, 3-byte and 4-byte cjk, broken sequence,
    // cut-short 4-byte lead with two continuations, cut-short 3-byte lead
    // with one, lone lead at the end, stray continuation, overlong form
    directed_items = '{
      9'h100,
      9'h07F, 9'h1FF,
      9'h0E4, 9'h0B8, 9'h1AD,
      9'h0F0, 9'h0A0, 9'h080, 9'h180,
      9'h0E4, 9'h141,
      9'h0F3, 9'h0B2, 9'h180,
      9'h0E9, 9'h1BF,
      9'h1E4,
      9'h180,
      9'h0F0, 9'h082, 9'h0BA, 9'h180
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed texts
    foreach (directed_items[i]) push_byte(directed_items[i][7:0], directed_items[i][8]);
    drain_results();

    // random texts, with a drain whenever a text ends between 1000 and 1029 bytes sent
    while (bytes_sent < ByteTarget) begin
      build_text();
      foreach (text_bytes[i]) push_byte(text_bytes[i], i == text_bytes.size() - 1);
      if (bytes_sent >= 1000 && bytes_sent < 1030) drain_results();
    end
    s_tvalid <= 1'b0;

    // wait for the tail, then verdict
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("utf8_cjk_text_classifier_unit_tb: clean");
    end else begin
      $display("utf8_cjk_text_classifier_unit_tb: errors");
    end
    $finish;
  end

endmodule
